### hw/rtl/nr_type1_codebook_precoder_gen_defines.svh
// Assertion macros shared by the checker of the codebook precoder generator.
// Every macro samples on the rising edge of clock; the first two are quiet during reset.
`ifndef NR_TYPE1_CODEBOOK_PRECODER_GEN_DEFINES_SVH
`define NR_TYPE1_CODEBOOK_PRECODER_GEN_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRT1CB_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("precoder check failed: same-cycle property");

// Consequent must hold in the cycle after the antecedent.
`define NRT1CB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("precoder check failed: next-cycle property");

// Next-cycle property that is also checked while reset is held.
`define NRT1CB_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("precoder check failed: reset property");

`endif

### hw/rtl/nrt1cb_pkg.sv
// Package for the Type I single-panel codebook precoder generator.
// Holds the request and weight types, the codebook tables and the amplitude lookup.
// Depends on nothing; used by every module of the block.
`default_nettype none

package nrt1cb_pkg;

   localparam int NUM_ROWS    = 32;
   localparam int ROW_BITS    = $clog2(NUM_ROWS);
   localparam int WEIGHT_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int COEF_FRAC   = (COEF_BITS < 16) ? COEF_BITS - 1 : 15;
   localparam int REQ_BITS    = 16;
   localparam int RSP_BITS    = 136;
   localparam real MATH_PI    = 3.14159265358979323846;

   localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(NUM_ROWS - 1);

   // Rank 2 second-beam offsets and rank 3/4 per-block column negation.
   localparam logic [3:0] OFF_H [4]    = '{4'd0, 4'd4, 4'd0, 4'd4};
   localparam logic [3:0] OFF_V [4]    = '{4'd0, 4'd0, 4'd4, 4'd4};
   localparam logic [3:0] NEG_MASK [4] = '{4'h0, 4'hA, 4'hC, 4'h6};

   // Rank codes as carried in rank_minus_one.
   localparam logic [1:0] RANK_1 = 2'd0;
   localparam logic [1:0] RANK_2 = 2'd1;
   localparam logic [1:0] RANK_3 = 2'd2;
   localparam logic [1:0] RANK_4 = 2'd3;

   typedef logic signed [WEIGHT_BITS-1:0] weight_type;

   typedef struct packed {
      logic [1:0] cophase_index;
      logic [1:0] offset_or_theta;
      logic [3:0] beam_v_index;
      logic [3:0] beam_h_index;
      logic [1:0] rank_minus_one;
   } req_type;

   typedef struct packed {
      weight_type col3_im;
      weight_type col3_re;
      weight_type col2_im;
      weight_type col2_re;
      weight_type col1_im;
      weight_type col1_re;
      weight_type col0_im;
      weight_type col0_re;
   } weights_type;

   // Amplitude cos(2*pi*j/16)/sqrt(32*rank), rounded to COEF_FRAC fraction bits and
   // aligned to Q1.15. The index is {rank_minus_one, j}; evaluated at elaboration only.
   function automatic weight_type amp_calc(int idx);
      int  j;
      int  r;
      int  q;
      real a;
      j = idx & 3;
      r = (idx >> 2) + 1;
      a = $cos(2.0 * MATH_PI * j / 16.0) * $pow(32.0 * r, -0.5);
      q = $rtoi(a * (2.0 ** COEF_FRAC) + 0.5);
      return WEIGHT_BITS'(q << (15 - COEF_FRAC));
   endfunction

   localparam weight_type AMP_LUT [16] = '{
      amp_calc(0),  amp_calc(1),  amp_calc(2),  amp_calc(3),
      amp_calc(4),  amp_calc(5),  amp_calc(6),  amp_calc(7),
      amp_calc(8),  amp_calc(9),  amp_calc(10), amp_calc(11),
      amp_calc(12), amp_calc(13), amp_calc(14), amp_calc(15)
   };

   // Cosine of a phase of p sixteenths of a turn, by quarter-wave symmetry.
   function automatic weight_type cos_lookup(logic [3:0] p, logic [1:0] rank_m1);
      logic [3:0] k;
      logic       neg;
      weight_type mag;
      k   = p;
      neg = 1'b0;
      case (p) inside
         [4'd0:4'd4]: begin
            k   = p;
            neg = 1'b0;
         end
         [4'd5:4'd8]: begin
            k   = 4'd8 - p;
            neg = 1'b1;
         end
         [4'd9:4'd12]: begin
            k   = p - 4'd8;
            neg = 1'b1;
         end
         default: begin
            k   = 4'd0 - p;
            neg = 1'b0;
         end
      endcase
      mag = (k == 4'd4) ? '0 : AMP_LUT[{rank_m1, k[1:0]}];
      return neg ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/nrt1cb_row_calc.sv
// Weights of one antenna port row of the Type I codebook precoder.
// Forms the four phases modulo 16 and looks up cosine and sine; uses nrt1cb_pkg.
`default_nettype none

module nrt1cb_row_calc
   import nrt1cb_pkg::*;
(
   input  req_type               req,
   input  logic [ROW_BITS-1:0]   row,
   output weights_type           weights
);

   logic [3:0] l;
   logic [3:0] m;
   logic [3:0] n4;
   logic [3:0] n1_wide;
   logic [3:0] k2;
   logic [3:0] lp;
   logic [3:0] mp;
   logic [3:0] pol_ph0;
   logic [3:0] pol_ph1;
   logic [3:0] base;
   logic [1:0] blk;
   logic [3:0] ph [4];
   weight_type re [4];
   weight_type im [4];
   logic [3:0] col_used;

   assign l       = req.beam_h_index;
   assign m       = req.beam_v_index;
   assign n4      = {req.cophase_index, 2'b00};
   assign n1_wide = {2'b00, row[3:2]};
   assign k2      = {2'b00, row[1:0]};
   assign blk     = row[4:3];

   // Second beam for rank 2.
   assign lp = l + OFF_H[req.offset_or_theta];
   assign mp = m + OFF_V[req.offset_or_theta];

   // Phase step between the two polarizations: 4n, plus a half turn on layer 1.
   assign pol_ph0 = row[4] ? n4 : 4'd0;
   assign pol_ph1 = row[4] ? (n4 + 4'd8) : 4'd0;

   // Rank 3/4 base phase; 2*l*n1 with n1 in 0..1.
   assign base = (row[2] ? {l[2:0], 1'b0} : 4'd0) + m * k2
               + (blk[0] ? {1'b0, req.offset_or_theta, 1'b0} : 4'd0)
               + (blk[1] ? n4 : 4'd0);

   always_comb begin
      if (req.rank_minus_one == RANK_1 || req.rank_minus_one == RANK_2) begin
         ph[0] = l * n1_wide + m * k2 + pol_ph0;
         ph[1] = lp * n1_wide + mp * k2 + pol_ph1;
         ph[2] = 4'd0;
         ph[3] = 4'd0;
      end else begin
         for (int c = 0; c < 4; c++) begin
            ph[c] = base + {NEG_MASK[blk][c], 3'b000};
         end
      end
   end

   assign col_used = {req.rank_minus_one == RANK_4,
                      req.rank_minus_one == RANK_3 || req.rank_minus_one == RANK_4,
                      req.rank_minus_one != RANK_1,
                      1'b1};

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         re[c] = col_used[c] ? cos_lookup(ph[c], req.rank_minus_one) : '0;
         im[c] = col_used[c] ? cos_lookup(ph[c] + 4'd12, req.rank_minus_one) : '0;
      end
   end

   assign weights.col0_re = re[0];
   assign weights.col0_im = im[0];
   assign weights.col1_re = re[1];
   assign weights.col1_im = im[1];
   assign weights.col2_re = re[2];
   assign weights.col2_im = im[2];
   assign weights.col3_re = re[3];
   assign weights.col3_im = im[3];

endmodule

`default_nettype wire

### hw/rtl/nr_type1_codebook_precoder_gen.sv
// A request's first row passes through the held request and then the output register.
// Throughput: one row per cycle when not stalled, set by the single row generator
// over the 32 antenna port rows; the next request is taken as row 31 is registered.
// Reset: synchronous, active high; clears cur_valid_ff, row_ff and rsp_valid_ff.
`default_nettype none

module nr_type1_codebook_precoder_gen
   import nrt1cb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Request channel.
   input  logic                req_tvalid,
   output logic                req_tready,
   // Fields from bit 0 up: rank_minus_one[1:0], beam_h_index[5:2], beam_v_index[9:6],
   // offset_or_theta[11:10], cophase_index[13:12], zero fill [15:14].
   input  logic [REQ_BITS-1:0] req_tdata,
   // Result channel, one transfer per antenna port row.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // Fields from bit 0 up: port_row[4:0], col0_re[20:5], col0_im[36:21], col1_re[52:37],
   // col1_im[68:53], col2_re[84:69], col2_im[100:85], col3_re[116:101],
   // col3_im[132:117], zero fill [135:133].
   output logic [RSP_BITS-1:0] rsp_tdata,
   // High on row 31, the last row of the matrix.
   output logic                rsp_tlast
);

   // The request being expanded is held here while its rows are generated.
   req_type               req_ff;
   req_type               req_in;
   logic                  cur_valid_ff;
   logic                  cur_valid_in;
   logic [ROW_BITS-1:0]   row_ff;
   logic [ROW_BITS-1:0]   row_in;

   // Output register; it lets the generator keep going while a row is taken.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   weights_type           weights_ff;
   weights_type           weights_in;
   logic [ROW_BITS-1:0]   out_row_ff;
   logic [ROW_BITS-1:0]   out_row_in;

   weights_type           row_weights;
   logic                  advance;
   logic                  on_last_row;
   logic                  req_accept;

   // A row moves into the output register whenever that register is empty or is being
   // emptied by a transfer in the same cycle.
   assign advance     = cur_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign on_last_row = (row_ff == LAST_ROW);

   // A new request is taken when nothing is held, or as the last row of the held one
   // moves out, so requests follow each other without a gap.
   assign req_tready = !cur_valid_ff || (advance && on_last_row);
   assign req_accept = req_tvalid && req_tready;

   nrt1cb_row_calc u_row_calc (
      .req     (req_ff),
      .row     (row_ff),
      .weights (row_weights)
   );

   always_comb begin
      req_in       = req_ff;
      cur_valid_in = cur_valid_ff;
      row_in       = row_ff;
      if (req_accept) begin
         req_in       = req_type'(req_tdata[$bits(req_type)-1:0]);
         cur_valid_in = 1'b1;
         row_in       = '0;
      end else if (advance) begin
         row_in = row_ff + 1'b1;
         if (on_last_row) begin
            cur_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      weights_in   = weights_ff;
      out_row_in   = out_row_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         weights_in   = row_weights;
         out_row_in   = row_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      weights_ff <= weights_in;
      out_row_ff <= out_row_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = (out_row_ff == LAST_ROW);
   assign rsp_tdata  = {3'b000,
                        weights_ff.col3_im, weights_ff.col3_re,
                        weights_ff.col2_im, weights_ff.col2_re,
                        weights_ff.col1_im, weights_ff.col1_re,
                        weights_ff.col0_im, weights_ff.col0_re,
                        out_row_ff};

endmodule

`default_nettype wire

### hw/rtl/nrt1cb_checker.sv
// Port-level checker for the codebook precoder generator, bound to the top level.
// Uses the assertion macros of nr_type1_codebook_precoder_gen_defines.svh and nrt1cb_pkg.
`default_nettype none

`include "nr_type1_codebook_precoder_gen_defines.svh"

module nrt1cb_checker
   import nrt1cb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_BITS-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   logic [ROW_BITS-1:0] rsp_row;
   logic                rsp_xfer;

   assign rsp_row  = rsp_tdata[ROW_BITS-1:0];
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // No result is offered right after reset.
   `NRT1CB_ASSERT_RESET(a_idle_after_reset, reset, !rsp_tvalid)

   // The last-row flag marks row 31 and nothing else.
   `NRT1CB_ASSERT_SAME(a_last_on_row31, rsp_tvalid, rsp_tlast == (rsp_row == LAST_ROW))

   // Inside a matrix the rows follow without a gap and in order.
   `NRT1CB_ASSERT_NEXT(a_rows_in_order, rsp_xfer && !rsp_tlast,
      rsp_tvalid && (rsp_row == $past(rsp_row) + 1'b1))

   // A stalled result holds its data.
   `NRT1CB_ASSERT_NEXT(a_stall_holds, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind nr_type1_codebook_precoder_gen nrt1cb_checker u_nrt1cb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
